// File: hdl/sbh_pkg.sv
// Shared types and constants for the subrange heap builder.
// No dependencies; imported by subrange_heap_builder.
package sbh_pkg;

	localparam int ELEM_W  = 32;
	localparam int IDX_W   = 6;
	localparam int REG_W   = 6;
	localparam int CIDX_W  = 2;
	localparam int SIDX_W  = 9;
	localparam int TDATA_W = 40;

	typedef logic signed [ELEM_W-1:0] elem_t;
	typedef logic [REG_W-1:0]         reg_t;
	typedef logic [CIDX_W-1:0]        cfg_idx_t;

	localparam cfg_idx_t CFG_HEAP_KIND    = 2'd0;
	localparam cfg_idx_t CFG_RANGE_START  = 2'd1;
	localparam cfg_idx_t CFG_RANGE_END    = 2'd2;
	localparam cfg_idx_t CFG_CHILD_OFFSET = 2'd3;

	localparam reg_t RANGE_END_RST = 6'd63;

	localparam logic KIND_MAX = 1'b0;

endpackage

// File: hdl/subrange_heap_builder.sv
// Subrange heap builder: loads elements, heapifies a subrange, streams the store out.
// Depends on sbh_pkg.
//
// channel | dir | fields (low bit up)                          | beat
// s_axis  | in  | tdata: elem_value[31:0]; tlast: elem_last    | one element
// m_axis  | out | tdata: out_value[31:0], out_index[37:32]; tlast: out_last | one element
// cfg     | in  | cfg_index, cfg_data                          | one register write
//
// Loading accepts one element per cycle; s_axis_tready stays high while loading.
// After the last element, a setup state; per node, a value read and then sift steps
// (check, child reads, right then left compare, swap), until the bottom or no better
// child; one compare unit. Emission uses a registered read and waits under stall.
// Reset is asynchronous; the store needs no clearing pass.
module subrange_heap_builder #(
	parameter int DEPTH = 64
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       s_axis_tvalid,
	output logic                       s_axis_tready,
	input  logic [31:0]                s_axis_tdata,  // elem_value
	input  logic                       s_axis_tlast,  // elem_last
	output logic                       m_axis_tvalid,
	input  logic                       m_axis_tready,
	output logic [sbh_pkg::TDATA_W-1:0] m_axis_tdata, // out_value, out_index, zero pad
	output logic                       m_axis_tlast,  // out_last
	input  logic                       cfg_we,
	input  sbh_pkg::cfg_idx_t          cfg_index,
	input  sbh_pkg::reg_t              cfg_data
);
	import sbh_pkg::*;

	localparam int AW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);
	localparam int GW = $clog2(DEPTH + 2);

	typedef enum logic [3:0] {
		ST_LOAD, ST_INIT, ST_VRD, ST_VLD, ST_CHK, ST_RD, ST_CMPR,
		ST_CMPL, ST_SW1, ST_SW2, ST_NEXT, ST_ERD, ST_ELD
	} state_t;

	typedef logic signed [SIDX_W-1:0] sidx_t;

	state_t          state_q;
	logic            kind_q;
	reg_t            start_q;
	reg_t            end_q;
	reg_t            off_q;
	logic [CW-1:0]   cnt_q;
	logic [AW-1:0]   hi_q;
	logic [AW-1:0]   bi_q;
	logic [AW-1:0]   pos_q;
	logic [AW-1:0]   best_q;
	logic [AW-1:0]   rc_q;
	logic [AW-1:0]   lc_q;
	logic            rc_ok_q;
	logic            lc_ok_q;
	logic [GW-1:0]   guard_q;
	logic [AW-1:0]   k_q;
	elem_t           v_q;
	elem_t           bestv_q;
	logic            ovalid_q;
	elem_t           ovalue_q;
	logic [IDX_W-1:0] oindex_q;
	logic            olast_q;

	elem_t           mem [DEPTH];
	elem_t           rda_q;
	elem_t           rdb_q;
	logic [AW-1:0]   addr_a;
	logic            we;
	logic [AW-1:0]   waddr;
	elem_t           wdata;

	logic            accept;
	logic [CW-1:0]   cnt_m1;
	logic [SIDX_W-1:0] hi_full;
	sidx_t           hi_s;
	sidx_t           lo_s;
	sidx_t           pos_s;
	sidx_t           off_s;
	sidx_t           rc_s;
	sidx_t           lc_s;
	elem_t           cmp_a;
	elem_t           cmp_b;
	logic            better;
	logic            out_free;

	assign accept        = s_axis_tvalid && s_axis_tready;
	assign s_axis_tready = (state_q == ST_LOAD);
	assign out_free      = !ovalid_q || m_axis_tready;

	assign m_axis_tvalid = ovalid_q;
	assign m_axis_tdata  = {{(TDATA_W - ELEM_W - IDX_W){1'b0}}, oindex_q, ovalue_q};
	assign m_axis_tlast  = olast_q;

	assign cnt_m1  = cnt_q - CW'(1);
	assign hi_full = (SIDX_W'(end_q) < SIDX_W'(cnt_m1)) ? SIDX_W'(end_q) : SIDX_W'(cnt_m1);
	assign hi_s    = signed'(SIDX_W'(hi_q));
	assign lo_s    = signed'(SIDX_W'(start_q));
	assign pos_s   = signed'(SIDX_W'(pos_q));
	assign off_s   = signed'(SIDX_W'(off_q));
	assign rc_s    = (pos_s <<< 1) + SIDX_W'(2) - off_s;
	assign lc_s    = (pos_s <<< 1) + SIDX_W'(1) - off_s;

	always_comb begin
		if (state_q == ST_CMPL) begin
			cmp_a = rdb_q;
			cmp_b = bestv_q;
		end else begin
			cmp_a = rda_q;
			cmp_b = v_q;
		end
		better = (kind_q == KIND_MAX) ? (cmp_a > cmp_b) : (cmp_a < cmp_b);
	end

	always_comb begin
		unique case (state_q)
			ST_VRD, ST_VLD: addr_a = bi_q;
			ST_ERD, ST_ELD: addr_a = k_q;
			default:        addr_a = rc_q;
		endcase
	end

	always_comb begin
		we    = 1'b0;
		waddr = pos_q;
		wdata = bestv_q;
		unique case (state_q)
			ST_LOAD: begin
				we    = accept && (cnt_q < CW'(DEPTH));
				waddr = AW'(cnt_q);
				wdata = elem_t'(s_axis_tdata);
			end
			ST_SW1: begin
				we = (best_q != pos_q);
			end
			ST_SW2: begin
				we    = 1'b1;
				waddr = best_q;
				wdata = v_q;
			end
			default: we = 1'b0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rda_q <= mem[addr_a];
		rdb_q <= mem[lc_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_LOAD;
			kind_q   <= KIND_MAX;
			start_q  <= '0;
			end_q    <= RANGE_END_RST;
			off_q    <= '0;
			cnt_q    <= '0;
			ovalid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					CFG_HEAP_KIND:    kind_q  <= cfg_data[0];
					CFG_RANGE_START:  start_q <= cfg_data;
					CFG_RANGE_END:    end_q   <= cfg_data;
					CFG_CHILD_OFFSET: off_q   <= cfg_data;
					default:          kind_q  <= kind_q;
				endcase
			end
			if (ovalid_q && m_axis_tready && (state_q != ST_ELD)) begin
				ovalid_q <= 1'b0;
			end
			unique case (state_q)
				ST_LOAD: begin
					if (accept) begin
						if (cnt_q < CW'(DEPTH)) begin
							cnt_q <= cnt_q + CW'(1);
						end
						if (s_axis_tlast) begin
							state_q <= ST_INIT;
						end
					end
				end
				ST_INIT: begin
					hi_q <= AW'(hi_full);
					k_q  <= '0;
					if (SIDX_W'(start_q) < hi_full) begin
						state_q <= ST_VRD;
						bi_q    <= AW'(lo_s + ((signed'(hi_full) - lo_s + SIDX_W'(1)) >>> 1)
							- SIDX_W'(1));
					end else begin
						state_q <= ST_ERD;
					end
				end
				ST_VRD: begin
					state_q <= ST_VLD;
				end
				ST_VLD: begin
					v_q     <= rda_q;
					pos_q   <= bi_q;
					guard_q <= '0;
					state_q <= ST_CHK;
				end
				ST_CHK: begin
					if ((pos_q < hi_q) && (guard_q <= GW'(DEPTH))) begin
						guard_q <= guard_q + GW'(1);
						rc_q    <= AW'(rc_s);
						lc_q    <= AW'(lc_s);
						rc_ok_q <= (rc_s >= 0) && (rc_s <= hi_s);
						lc_ok_q <= (lc_s >= 0) && (lc_s <= hi_s);
						state_q <= ST_RD;
					end else begin
						state_q <= ST_NEXT;
					end
				end
				ST_RD: begin
					state_q <= ST_CMPR;
				end
				ST_CMPR: begin
					if (rc_ok_q && better) begin
						best_q  <= rc_q;
						bestv_q <= rda_q;
					end else begin
						best_q  <= pos_q;
						bestv_q <= v_q;
					end
					state_q <= ST_CMPL;
				end
				ST_CMPL: begin
					if (lc_ok_q && better) begin
						best_q  <= lc_q;
						bestv_q <= rdb_q;
					end
					state_q <= ST_SW1;
				end
				ST_SW1: begin
					state_q <= (best_q == pos_q) ? ST_NEXT : ST_SW2;
				end
				ST_SW2: begin
					pos_q   <= best_q;
					state_q <= ST_CHK;
				end
				ST_NEXT: begin
					if (SIDX_W'(bi_q) == SIDX_W'(start_q)) begin
						state_q <= ST_ERD;
					end else begin
						bi_q    <= bi_q - AW'(1);
						state_q <= ST_VRD;
					end
				end
				ST_ERD: begin
					state_q <= ST_ELD;
				end
				ST_ELD: begin
					if (out_free) begin
						ovalid_q <= 1'b1;
						ovalue_q <= rda_q;
						oindex_q <= IDX_W'(k_q);
						olast_q  <= (CW'(k_q) == cnt_m1);
						if (CW'(k_q) == cnt_m1) begin
							cnt_q   <= '0;
							state_q <= ST_LOAD;
						end else begin
							k_q     <= k_q + AW'(1);
							state_q <= ST_ERD;
						end
					end
				end
				default: state_q <= ST_LOAD;
			endcase
		end
	end

endmodule
